@@ sv/lprl_pkg.sv @@
package lprl_pkg;

   localparam int ROUTES = 16;
   localparam int IDX_W  = (ROUTES > 1) ? $clog2(ROUTES) : 1;
   localparam int CNT_W  = $clog2(ROUTES + 1);

   typedef enum logic [1:0] {
      ACT_LOOKUP = 2'd0,
      ACT_APPEND = 2'd1,
      ACT_CLEAR  = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [1:0]  action;
      logic [31:0] dest_ip;
      logic [31:0] route_prefix;
      logic [31:0] route_mask;
      logic [31:0] route_gateway;
   } req_type;

   typedef struct packed {
      logic [31:0] next_hop_ip;
      logic        matched;
      logic        accepted;
      logic [4:0]  entry_count;
   } rsp_type;

   typedef struct packed {
      logic [31:0] prefix;
      logic [31:0] mask;
      logic [31:0] gateway;
   } route_entry_type;

   typedef struct packed {
      logic clear;
      logic valid;
   } match_ctl_type;

endpackage

@@ sv/lprl_match_unit.sv @@
module lprl_match_unit
   import lprl_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  match_ctl_type   ctl,
   input  route_entry_type entry,
   input  logic [31:0]     dest_ip,
   output logic            found,
   output logic [31:0]     best_gateway
);

   logic [31:0] best_mask_ff, best_mask_in;
   logic [31:0] best_gw_ff, best_gw_in;
   logic        found_ff, found_in;
   logic        hit;

   assign hit = (((entry.prefix ^ dest_ip) & entry.mask) == 32'd0) &&
                (entry.mask >= best_mask_ff);

   always_comb begin
      best_mask_in = best_mask_ff;
      best_gw_in   = best_gw_ff;
      found_in     = found_ff;
      if (ctl.clear) begin
         best_mask_in = 32'd0;
         best_gw_in   = 32'd0;
         found_in     = 1'b0;
      end else if (ctl.valid && hit) begin
         best_mask_in = entry.mask;
         best_gw_in   = entry.gateway;
         found_in     = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
      best_mask_ff <= best_mask_in;
      best_gw_ff   <= best_gw_in;
   end

   assign found        = found_ff;
   assign best_gateway = best_gw_ff;

endmodule

@@ sv/longest_prefix_route_lookup_core.sv @@
// Longest-prefix route lookup. Give one beat on req with start while busy is
// low. Append, clear, the unused code and a lookup of an empty table show
// their result in the cycle right after the accepting edge. A lookup scans
// the route memory in ST_SCAN, one entry per cycle through a single
// match/compare unit, then passes ST_DRAIN and shows its result in ST_DONE.
// Each beat on rsp is marked by rsp_strobe for exactly one cycle and cannot
// be held off, so it must be taken when shown. An append to a full table is
// refused with accepted low.
module longest_prefix_route_lookup_core
   import lprl_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  req_type req,
   output logic    busy,
   output logic    rsp_strobe,
   output rsp_type rsp
);

   state_type       state_ff, state_in;
   req_type         req_ff, req_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic            acc_ff, acc_in;
   logic            rd_vld_ff, rd_vld_in;
   route_entry_type rd_ff;
   route_entry_type mem [ROUTES];

   logic            accept;
   logic            wr_en;
   logic            rd_en;
   logic            room;
   logic            last_issue;
   match_ctl_type   mctl;
   logic            found;
   logic [31:0]     best_gw;

   assign accept     = start && (state_ff == ST_IDLE);
   assign room       = count_ff < CNT_W'(ROUTES);
   assign last_issue = (CNT_W'(idx_ff) + CNT_W'(1)) == count_ff;

   always_comb begin
      state_in  = state_ff;
      req_in    = req_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      acc_in    = acc_ff;
      rd_vld_in = 1'b0;
      wr_en     = 1'b0;
      rd_en     = 1'b0;
      mctl      = '{clear: 1'b0, valid: rd_vld_ff};
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               req_in = req;
               acc_in = 1'b0;
               idx_in = '0;
               mctl.clear = 1'b1;
               state_in = ST_DONE;
               case (req.action)
                  ACT_LOOKUP: begin
                     if (count_ff != '0) begin
                        state_in = ST_SCAN;
                     end
                  end
                  ACT_APPEND: begin
                     if (room) begin
                        wr_en    = 1'b1;
                        count_in = count_ff + CNT_W'(1);
                        acc_in   = 1'b1;
                     end
                  end
                  ACT_CLEAR: begin
                     count_in = '0;
                     acc_in   = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            rd_en     = 1'b1;
            rd_vld_in = 1'b1;
            idx_in    = idx_ff + IDX_W'(1);
            if (last_issue) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         rd_vld_ff <= rd_vld_in;
      end
      req_ff <= req_in;
      idx_ff <= idx_in;
      acc_ff <= acc_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[count_ff[IDX_W-1:0]] <= '{prefix:  req.route_prefix,
                                       mask:    req.route_mask,
                                       gateway: req.route_gateway};
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_ff <= mem[idx_ff];
      end
   end

   lprl_match_unit u_match (
      .clock        (clock),
      .reset        (reset),
      .ctl          (mctl),
      .entry        (rd_ff),
      .dest_ip      (req_ff.dest_ip),
      .found        (found),
      .best_gateway (best_gw)
   );

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = (state_ff == ST_DONE);

   always_comb begin
      rsp.next_hop_ip = 32'd0;
      rsp.matched     = 1'b0;
      rsp.accepted    = acc_ff;
      rsp.entry_count = 5'(count_ff);
      if (req_ff.action == ACT_LOOKUP) begin
         rsp.matched     = found;
         rsp.next_hop_ip = (found && (best_gw != 32'd0)) ? best_gw : req_ff.dest_ip;
      end
   end

endmodule

@@ sv/lprl_checker.sv @@
module lprl_checker
   import lprl_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input req_type req,
   input logic    busy,
   input logic    rsp_strobe,
   input rsp_type rsp
);

   a_accept_busy : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted beat did not raise busy");

   a_strobe_busy : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("result beat while idle");

   a_strobe_single : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> (!rsp_strobe && !busy))
      else $error("result beat not followed by idle");

   a_update_fields : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp.accepted) |-> (!rsp.matched && rsp.next_hop_ip == 32'd0))
      else $error("table update beat carries lookup fields");

   a_count_range : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp.entry_count <= 5'(ROUTES)))
      else $error("entry count beyond table size");

endmodule

bind longest_prefix_route_lookup_core lprl_checker u_lprl_checker (.*);
